[sv/pvsd_pkg.sv]
// ----------------------------------------------------------------------------
// pvsd_pkg: packed vector stream decoder package
// component selection codes, float constants and the half-to-single widening
// ----------------------------------------------------------------------------
`default_nettype none

package pvsd_pkg;

    // component select field of the code byte
    typedef enum logic [1:0] {
        SEL_VALUE   = 2'd0,
        SEL_ZERO    = 2'd1,
        SEL_ONE     = 2'd2,
        SEL_NEG_ONE = 2'd3
    } comp_sel_t;

    localparam int unsigned CODE_COPY_BIT = 6;

    localparam logic [31:0] FLOAT_ZERO    = 32'h0000_0000;
    localparam logic [31:0] FLOAT_ONE     = 32'h3F80_0000;
    localparam logic [31:0] FLOAT_NEG_ONE = 32'hBF80_0000;

    // exponent rebias from 5-bit to 8-bit form, no special case for zero
    localparam logic [7:0] EXP_REBIAS = 8'd112;

    function automatic logic [31:0] const_bits(input comp_sel_t sel);
        logic [31:0] r;
        r = FLOAT_ZERO;
        unique case (sel)
            SEL_VALUE:   r = FLOAT_ZERO;
            SEL_ZERO:    r = FLOAT_ZERO;
            SEL_ONE:     r = FLOAT_ONE;
            SEL_NEG_ONE: r = FLOAT_NEG_ONE;
            default:     r = FLOAT_ZERO;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] v);
        logic [7:0] exp_w;
        exp_w = {3'b000, v[14:10]} + EXP_REBIAS;
        return {v[15], exp_w, v[9:0], 13'b0};
    endfunction

endpackage

`default_nettype wire

[sv/packed_vector_stream_decoder.sv]
// ----------------------------------------------------------------------------
// packed_vector_stream_decoder: byte stream to single-precision vectors
// parses code bytes and 16-bit little-endian values into x, y, z bit patterns
// ----------------------------------------------------------------------------
// path: a record's last byte goes into the input register, then is decoded
//   into the result register that drives out_valid
// throughput: one byte per cycle, set by the single decode stage,
// but a stalled result holds only bytes that would complete another record
// reset: asynchronous, active low; parser waits for a code byte, held
//   components and code cleared, both registers empty
// ----------------------------------------------------------------------------
`default_nettype none

module packed_vector_stream_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  stream_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      x_bits,
    output logic [31:0]      y_bits,
    output logic [31:0]      z_bits
);

    // which byte of the record comes next
    typedef enum logic [2:0] {
        PH_CODE = 3'd0,
        PH_X_LO = 3'd1,
        PH_X_HI = 3'd2,
        PH_Y_LO = 3'd3,
        PH_Y_HI = 3'd4,
        PH_Z_LO = 3'd5,
        PH_Z_HI = 3'd6
    } phase_t;

    // input register
    logic        byte_valid_reg;
    logic [7:0]  byte_reg;

    // parser state
    phase_t      phase_reg,    phase_next;
    logic [7:0]  code_reg,     code_next;
    logic [7:0]  low_reg,      low_next;
    logic [31:0] x_reg,        x_next;
    logic [31:0] y_reg,        y_next;

    // result register
    logic        out_valid_reg;
    logic [31:0] x_out_reg;
    logic [31:0] y_out_reg;
    logic [31:0] z_out_reg;

    logic        emit;       // byte in the input register completes a record
    logic [31:0] z_val;
    logic        fire;       // decode stage consumes its byte this cycle
    logic        in_xfer;

    // ------------------------------------------------------------------------
    // decode: one byte against the held parse state
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic [1:0]  start;
        logic        run;
        logic        done;
        logic [31:0] hv;
        pvsd_pkg::comp_sel_t sel;

        phase_next = phase_reg;
        code_next  = code_reg;
        low_next   = low_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        emit       = 1'b0;
        z_val      = x_reg;
        start      = 2'd0;
        run        = 1'b0;
        done       = 1'b0;
        hv         = pvsd_pkg::widen_half({byte_reg, low_reg});
        sel        = pvsd_pkg::SEL_VALUE;

        unique case (phase_reg)
            PH_X_LO, PH_Y_LO, PH_Z_LO:
            begin
                low_next = byte_reg;
                unique case (phase_reg)
                    PH_X_LO: phase_next = PH_X_HI;
                    PH_Y_LO: phase_next = PH_Y_HI;
                    default: phase_next = PH_Z_HI;
                endcase
            end
            PH_X_HI:
            begin
                x_next = hv;
                start  = 2'd1;
                run    = 1'b1;
            end
            PH_Y_HI:
            begin
                y_next = hv;
                start  = 2'd2;
                run    = 1'b1;
            end
            PH_Z_HI:
            begin
                emit       = 1'b1;
                z_val      = hv;
                phase_next = PH_CODE;
            end
            default:
            begin
                // code byte, also taken in the unreachable spare phase
                code_next = byte_reg;
                start     = 2'd0;
                run       = 1'b1;
            end
        endcase

        // resolve constant components until a value must be read or the record ends
        if (run)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (!done && (k >= int'(start)))
                begin
                    sel = pvsd_pkg::comp_sel_t'(code_next[2*k +: 2]);
                    if ((k > 0) && code_next[pvsd_pkg::CODE_COPY_BIT])
                    begin
                        // y and z follow x
                        y_next     = x_next;
                        z_val      = x_next;
                        emit       = 1'b1;
                        phase_next = PH_CODE;
                        done       = 1'b1;
                    end
                    else if (sel == pvsd_pkg::SEL_VALUE)
                    begin
                        if (k == 0)
                            phase_next = PH_X_LO;
                        else if (k == 1)
                            phase_next = PH_Y_LO;
                        else
                            phase_next = PH_Z_LO;
                        done = 1'b1;
                    end
                    else if (k == 0)
                    begin
                        x_next = pvsd_pkg::const_bits(sel);
                    end
                    else if (k == 1)
                    begin
                        y_next = pvsd_pkg::const_bits(sel);
                    end
                    else
                    begin
                        z_val      = pvsd_pkg::const_bits(sel);
                        emit       = 1'b1;
                        phase_next = PH_CODE;
                        done       = 1'b1;
                    end
                end
            end
        end
    end

    // a byte that completes a record waits for room in the result register
    assign fire     = byte_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !byte_valid_reg || fire;
    assign in_xfer  = in_valid && in_ready;

    // ------------------------------------------------------------------------
    // state and registered outputs
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            phase_reg      <= PH_CODE;
            code_reg       <= 8'd0;
            low_reg        <= 8'd0;
            x_reg          <= 32'd0;
            y_reg          <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                byte_valid_reg <= 1'b1;
                byte_reg       <= stream_byte;
            end
            else if (fire)
            begin
                byte_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                phase_reg <= phase_next;
                code_reg  <= code_next;
                low_reg   <= low_next;
                x_reg     <= x_next;
                y_reg     <= y_next;
            end

            if (fire && emit)
            begin
                out_valid_reg <= 1'b1;
                x_out_reg     <= x_next;
                y_out_reg     <= y_next;
                z_out_reg     <= z_val;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign x_bits    = x_out_reg;
    assign y_bits    = y_out_reg;
    assign z_bits    = z_out_reg;

`ifndef SYNTHESIS
    // a completed record always lands in the result register
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> out_valid_reg)
        else $error("completed record not loaded into result register");

    // a completed record returns the parser to the code byte
    a_emit_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> phase_reg == PH_CODE)
        else $error("parser not back at code byte after record");

    // a byte held in the input register is neither lost nor overwritten
    a_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid_reg && !fire |=> byte_valid_reg && $stable(byte_reg))
        else $error("stalled byte lost or overwritten");

    // an x low byte is always followed by its high byte
    a_low_then_high: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_X_LO |=> phase_reg == PH_X_HI)
        else $error("x high byte phase skipped");
`endif

endmodule

`default_nettype wire

[tb/tb_packed_vector_stream_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_vector_stream_decoder: self-checking bench for the vector decoder
// drives encoded byte records through the input handshake, predicts every
// x/y/z vector from a local model of the record parser and compares each
// output transfer against the oldest predicted vector, under varied idling
// ----------------------------------------------------------------------------
`default_nettype none

module tb_packed_vector_stream_decoder;

    // 16-bit exponent bias 15 widened to single bias 127
    localparam logic [7:0] HALF_EXP_OFFSET = 8'd112;

    // parse phases of the record parser
    localparam logic [2:0] PH_CODE   = 3'd0;
    localparam logic [2:0] PH_UNUSED = 3'd7;

    // drain time for the input and result registers, plus margin
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } vec3_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  stream_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] z_bits;

    // vectors predicted but not yet seen at the output
    vec3_t       expected_vectors[$];

    // local copy of the parser state
    logic [2:0]  parse_phase;
    logic [7:0]  rec_code;
    logic [7:0]  low_byte;
    logic [31:0] x_acc;
    logic [31:0] y_acc;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    packed_vector_stream_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .x_bits      (x_bits),
        .y_bits      (y_bits),
        .z_bits      (z_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // vector prediction
    // ------------------------------------------------------------------------

    // sign kept, exponent rebiased with no zero/inf/nan handling,
    // mantissa left-aligned into the 23-bit field
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [7:0] e;
        e = {3'b000, h[14:10]} + HALF_EXP_OFFSET;
        return {h[15], e, h[9:0], 13'd0};
    endfunction

    // record complete: queue the vector and go back to waiting for a code byte
    task automatic finish_record(input logic [31:0] z_val);
        vec3_t v;
        v.x = x_acc;
        v.y = y_acc;
        v.z = z_val;
        expected_vectors.push_back(v);
        parse_phase = PH_CODE;
    endtask

    // walk the components from comp onwards until one needs value bytes,
    // the copy bit ends the record, or z is settled from a constant
    task automatic resolve_components(input int unsigned comp);
        pvsd_pkg::comp_sel_t sel;
        logic [31:0] cval;
        bit          stop;
        stop = 1'b0;
        while (!stop && comp < 3)
        begin
            if (comp > 0 && rec_code[pvsd_pkg::CODE_COPY_BIT])
            begin
                // y and z mirror x, no further bytes
                y_acc = x_acc;
                finish_record(x_acc);
                stop = 1'b1;
            end
            else
            begin
                sel = pvsd_pkg::comp_sel_t'(rec_code[2*comp +: 2]);
                if (sel == pvsd_pkg::SEL_VALUE)
                begin
                    parse_phase = 3'(2 * comp + 1);
                    stop = 1'b1;
                end
                else
                begin
                    case (sel)
                        pvsd_pkg::SEL_ONE:     cval = pvsd_pkg::FLOAT_ONE;
                        pvsd_pkg::SEL_NEG_ONE: cval = pvsd_pkg::FLOAT_NEG_ONE;
                        default:               cval = pvsd_pkg::FLOAT_ZERO;
                    endcase
                    if (comp == 0)
                        x_acc = cval;
                    else if (comp == 1)
                        y_acc = cval;
                    else
                    begin
                        finish_record(cval);
                        stop = 1'b1;
                    end
                    comp++;
                end
            end
        end
        if (!stop)
            parse_phase = PH_CODE;
    endtask

    // advance the parser model by one transferred byte
    task automatic predict_byte(input logic [7:0] b);
        int unsigned comp;
        logic [31:0] val;
        if (parse_phase == PH_CODE || parse_phase == PH_UNUSED)
        begin
            rec_code = b;
            resolve_components(0);
        end
        else if (parse_phase[0])
        begin
            // odd phase: low byte of a little-endian value
            low_byte    = b;
            parse_phase = parse_phase + 3'd1;
        end
        else
        begin
            // even phase 2, 4, 6: high byte of x, y, z
            comp = 32'(parse_phase[2:1]) - 1;
            val  = half_to_single({b, low_byte});
            if (comp == 0)
            begin
                x_acc = val;
                resolve_components(1);
            end
            else if (comp == 1)
            begin
                y_acc = val;
                resolve_components(2);
            end
            else
                finish_record(val);
        end
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // one byte transfer, with random idle cycles ahead of it; valid is left
    // high afterwards so back-to-back bytes need no extra assignment
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid    <= 1'b0;
            stream_byte <= 8'($urandom);
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(b);
    endtask

    // hold the sender off until every predicted vector has come out
    task automatic wait_all_delivered();
        in_valid <= 1'b0;
        while (expected_vectors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // half-precision value: mostly random, sometimes a field extreme
    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7C00;
            3:       return 16'h83FF;
            default: return 16'($urandom);
        endcase
    endfunction

    // number of value bytes a code byte calls for
    function automatic int unsigned value_bytes_for(input logic [7:0] code);
        int unsigned n;
        n = 0;
        if (pvsd_pkg::comp_sel_t'(code[1:0]) == pvsd_pkg::SEL_VALUE)
            n += 2;
        if (!code[pvsd_pkg::CODE_COPY_BIT])
        begin
            if (pvsd_pkg::comp_sel_t'(code[3:2]) == pvsd_pkg::SEL_VALUE)
                n += 2;
            if (pvsd_pkg::comp_sel_t'(code[5:4]) == pvsd_pkg::SEL_VALUE)
                n += 2;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // compare every output transfer with the oldest predicted vector
    always @(posedge clk)
    begin
        vec3_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_vectors.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected vector x=%h y=%h z=%h", x_bits, y_bits, z_bits);
            end
            else
            begin
                want = expected_vectors.pop_front();
                if (x_bits !== want.x || y_bits !== want.y || z_bits !== want.z)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("vector mismatch: exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                                 want.x, want.y, want.z, x_bits, y_bits, z_bits);
                end
            end
        end
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // records whose components are all constants finish on the code byte
    task automatic test_constant_records();
        send_byte(8'h15);   // all 0.0
        send_byte(8'h2A);   // all 1.0
        send_byte(8'h3F);   // all -1.0
        send_byte(8'h39);   // 0.0, 1.0, -1.0
    endtask

    // copy bit: y and z follow x, whether x is constant or a value
    task automatic test_copy_records();
        send_byte(8'h42);   // x = 1.0, copied
        send_byte(8'hC3);   // bit 7 set as well, x = -1.0, copied
        send_byte(8'h40);   // x from value bytes, copied
        send_byte(8'h00);   // all-zero value decodes to a non-zero pattern
        send_byte(8'h00);
    endtask

    // value components at the extremes of sign, exponent and mantissa, then a mix
    task automatic test_value_records();
        send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'hFF);   // 0xFFFF
        send_byte(8'h00); send_byte(8'h7C);   // 0x7C00
        send_byte(8'h00); send_byte(8'h80);   // 0x8000
        send_byte(8'h80);                     // bit 7 ignored
        send_byte(8'hFF); send_byte(8'h03);   // 0x03FF
        send_byte(8'h01); send_byte(8'h00);   // 0x0001
        send_byte(8'hFF); send_byte(8'h7F);   // 0x7FFF
        send_byte(8'h34);                     // x value, y 0.0, z -1.0
        send_byte(8'h5A); send_byte(8'hA5);
    endtask

    // mostly well-formed records with random content, some truncated
    // records and stray bytes that shift the framing
    task automatic test_random_stream(input int unsigned n_bytes,
                                      input int unsigned idle_pct,
                                      input int unsigned stall_pct);
        int unsigned sent;
        int unsigned need;
        int unsigned roll;
        logic [7:0]  code;
        logic [15:0] half;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_bytes)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                send_byte(8'($urandom));
                sent++;
            end
            else
            begin
                code = 8'($urandom);
                need = value_bytes_for(code);
                // a truncated record lets the next code byte land as data
                if (roll < 16 && need > 0)
                    need = $urandom_range(0, need - 1);
                send_byte(code);
                sent++;
                while (need > 0)
                begin
                    half = pick_half();
                    send_byte(half[7:0]);
                    sent++;
                    need--;
                    if (need > 0)
                    begin
                        send_byte(half[15:8]);
                        sent++;
                        need--;
                    end
                end
            end
        end
        wait_all_delivered();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        stream_byte    = 8'h00;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        parse_phase    = PH_CODE;
        rec_code       = 8'h00;
        low_byte       = 8'h00;
        x_acc          = 32'h0;
        y_acc          = 32'h0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_constant_records();
        test_copy_records();
        test_value_records();
        wait_all_delivered();

        // no idling, sender sparse, receiver stalling, light idling on both
        test_random_stream(470, 0, 0);
        test_random_stream(470, 83, 0);
        test_random_stream(470, 0, 83);
        test_random_stream(470, 8, 8);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_vectors.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
sv/pvsd_pkg.sv
sv/packed_vector_stream_decoder.sv
tb/tb_packed_vector_stream_decoder.sv
